/* design/lpvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvs_pkg
// Shared widths, field layout and controller/datapath handshake structs for
// the LRU page victim selector.
// ----------------------------------------------------------------------------
package lpvs_pkg;

  // field widths
  localparam int IDX_W   = 5;
  localparam int PC_W    = 12;
  localparam int MASK_W  = 32;
  localparam int CNT_W   = 6;
  localparam int PAGE_W  = 5;
  localparam int STAMP_W = 32;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // wide enough for any slot * pages + page product
  localparam int EXT_W = 13;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;   // write one zero entry of the clearing pass
    logic load;       // capture the input beat
    logic decide;     // stamp the page, set requests, set up the scan
    logic scan;       // walk the stamps of the process
    logic finish;     // load the output register, advance the tick after a sweep end
  } lpvs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;   // last entry of the clearing pass written this cycle
    logic need_scan;  // needed page missing and no frame free
    logic scan_done;  // all stamps read and compared
    logic out_busy;   // output register still holds an untaken beat
  } lpvs_sts_t;

endpackage

/* design/lpvs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvs_ctrl
// Sequencer of the victim selector: clearing pass after reset, then one
// item at a time through divide, decide, an optional scan and output.
// ----------------------------------------------------------------------------
module lpvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output lpvs_pkg::lpvs_cmd_t cmd,
  input  lpvs_pkg::lpvs_sts_t sts
);
  import lpvs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  // decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && in_tvalid && in_tready_r;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.scan     = (state_r == S_SCAN);
    cmd.finish   = (state_r == S_OUT) && !sts.out_busy;
  end

  // state and ready register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_done) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_DIV;
            in_tready_r <= 1'b0;
          end
        end
        S_DIV: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          state_r <= sts.need_scan ? S_SCAN : S_OUT;
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!sts.out_busy) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_CLEAR;
          in_tready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/lpvs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvs_datapath
// Item registers, page divider, stamp memory, victim scan and output
// register of the LRU page victim selector.
// ----------------------------------------------------------------------------
module lpvs_datapath #(
  parameter int NUM_PROCESSES     = 32,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PAGE_BYTES        = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpvs_pkg::lpvs_cmd_t                 cmd,
  output lpvs_pkg::lpvs_sts_t                 sts,
  input  logic [lpvs_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpvs_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import lpvs_pkg::*;

  localparam int DEPTH   = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int USABLE  = (PAGES_PER_PROCESS < 32) ? PAGES_PER_PROCESS : 32;
  // reciprocal for exact division of a PC_W-bit value by PAGE_BYTES
  localparam int DIV_L   = $clog2(PAGE_BYTES);
  localparam int DIV_S   = PC_W + DIV_L;
  localparam int RW      = PC_W + 1;
  localparam int PW      = PC_W + RW;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << DIV_S) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

  // item registers
  logic [IDX_W-1:0]   idx_r;
  logic               act_r;
  logic [PC_W-1:0]    pc_r;
  logic [MASK_W-1:0]  mask_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               frame_r;
  logic               last_r;
  logic [PW-1:0]      prod_r;

  // result and scan registers
  logic               pin_r;
  logic [PAGE_W-1:0]  needed_r;
  logic               found_r;
  logic [PAGE_W-1:0]  best_r;
  logic [STAMP_W-1:0] oldest_r;
  logic [CNT_W-1:0]   p_r;
  logic [CNT_W-1:0]   limit_r;
  logic [AW-1:0]      base_r;
  logic               rd_vld_r;
  logic [PAGE_W-1:0]  rd_page_r;
  logic [STAMP_W-1:0] rdata_r;

  logic [STAMP_W-1:0] tick_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [STAMP_W-1:0] mem [DEPTH];

  logic [PC_W-1:0]    page_full;
  logic               slot_ok;
  logic               page_ok;
  logic               nonres;
  logic [EXT_W-1:0]   base_ext;
  logic [AW-1:0]      base_addr;
  logic [AW-1:0]      stamp_addr;
  logic               scan_issue;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [STAMP_W-1:0] mem_wd;

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_tdata[4:0];
      act_r   <= in_tdata[5];
      pc_r    <= in_tdata[17:6];
      mask_r  <= in_tdata[49:18];
      cnt_r   <= in_tdata[55:50];
      frame_r <= in_tdata[56];
      last_r  <= in_tlast;
    end
  end

  // page = pc / PAGE_BYTES by reciprocal multiply
  always_ff @(posedge clk) begin
    prod_r <= PW'(pc_r) * PW'(RECIP);
  end

  assign page_full  = PC_W'(prod_r >> DIV_S);
  assign slot_ok    = act_r && ({2'b00, idx_r} < 7'(NUM_PROCESSES));
  assign page_ok    = page_full < PC_W'(USABLE);
  assign nonres     = !mask_r[page_full[PAGE_W-1:0]];
  assign base_ext   = EXT_W'(idx_r) * EXT_W'(PAGES_PER_PROCESS);
  assign base_addr  = AW'(base_ext);
  assign stamp_addr = AW'(base_ext + EXT_W'(page_full));

  assign scan_issue = cmd.scan && (p_r < limit_r);
  assign rd_addr    = AW'(EXT_W'(base_r) + EXT_W'(p_r));

  // memory write port: clearing pass or stamp
  always_comb begin
    mem_we = cmd.clr_step || (cmd.decide && slot_ok && page_ok);
    mem_wa = cmd.clr_step ? clr_cnt_r : stamp_addr;
    mem_wd = cmd.clr_step ? '0 : tick_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // registered stamp read
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step && (clr_cnt_r != AW'(DEPTH - 1))) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // decide and scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      p_r      <= '0;
      limit_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
      if (cmd.decide) begin
        pin_r    <= slot_ok && page_ok && nonres && frame_r;
        needed_r <= slot_ok ? page_full[PAGE_W-1:0] : '0;
        found_r  <= 1'b0;
        best_r   <= '0;
        oldest_r <= tick_r;
        p_r      <= '0;
        limit_r  <= (cnt_r < CNT_W'(USABLE)) ? cnt_r : CNT_W'(USABLE);
        base_r   <= base_addr;
      end else begin
        if (scan_issue) begin
          rd_page_r <= p_r[PAGE_W-1:0];
          p_r       <= p_r + 1'b1;
        end
        // keep the strictly older stamp; ties stay with the lower page
        if (rd_vld_r && mask_r[rd_page_r] && (rdata_r < oldest_r)) begin
          oldest_r <= rdata_r;
          best_r   <= rd_page_r;
          found_r  <= 1'b1;
        end
      end
    end
  end

  // tick and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= STAMP_W'(1);
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        tick_r     <= tick_r + STAMP_W'(last_r);
        out_vld_r  <= 1'b1;
        out_data_r <= {4'b0000, (found_r ? best_r : PAGE_W'(0)), found_r,
                       needed_r, pin_r};
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts           = '0;
    sts.clr_done  = cmd.clr_step && (clr_cnt_r == AW'(DEPTH - 1));
    sts.need_scan = slot_ok && page_ok && nonres && !frame_r;
    sts.scan_done = (p_r == limit_r) && !rd_vld_r;
    sts.out_busy  = out_vld_r && !out_tready;
  end

  // scan pointer never runs past the limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (p_r <= limit_r))
    else $error("scan pointer past limit");

  // a chosen victim lies below the limit
  a_victim_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> ({1'b0, best_r} < limit_r))
    else $error("victim outside scanned range");

  // never overwrite an untaken output beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_vld_r && !out_tready))
    else $error("output beat overwritten");

  // page-in and page-out never asked together
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_data_r[0] && out_data_r[6]))
    else $error("page-in and page-out both set");

endmodule

/* design/lru_page_victim_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_victim_select_top
// LRU page replacement: stamps the page under each active process's program
// counter and picks the least recently used resident page for eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one beat per process slot of a scheduling sweep;
//   in_tlast marks the last slot of a sweep and advances the use tick after
//   that beat. Output stream out_*: exactly one result beat per input beat,
//   in order.
//   Flow: an item passes through the divide and decide steps and, when a
//   victim must be chosen, the scan of the process's page stamps (page_count
//   capped at the usable pages, at most 32) before the output register. The
//   scan reads one stamp per cycle from the stamp memory; that read loop sets
//   the rate. A new item is accepted only after the current one has loaded
//   the output register.
//   Reset: the stamp memory is swept to zero, one entry per cycle, over all
//   NUM_PROCESSES * PAGES_PER_PROCESS entries (1024 by default) with in_tready
//   low; the tick restarts at one.
//   Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and held at its output step until out_tready frees the
//   register.
// ----------------------------------------------------------------------------
module lru_page_victim_select_top #(
  parameter int NUM_PROCESSES     = 32,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PAGE_BYTES        = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [4:0] process_index, [5] process_active, [17:6] program_counter,
  // [49:18] resident_mask, [55:50] page_count, [56] frame_available
  input  logic [lpvs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // sweep_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] pagein_request, [5:1] needed_page, [6] pageout_request,
  // [11:7] victim_page
  output logic [lpvs_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lpvs_pkg::*;

  lpvs_cmd_t cmd;
  lpvs_sts_t sts;

  // sequencer
  lpvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath with stamp memory
  lpvs_datapath #(
    .NUM_PROCESSES     (NUM_PROCESSES),
    .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
    .PAGE_BYTES        (PAGE_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
